@@ design/rmq_pkg.sv @@
// Shared types and constants for the range minimum query block.
`default_nettype none
package rmq_pkg;
  localparam int unsigned POS_BITS = 12;
  localparam int unsigned LEN_BITS = 13;
  localparam int unsigned IN_VALUE_BITS = 16;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } scan_state_t;
endpackage
`default_nettype wire

@@ design/rmq_store.sv @@
// Value store: synchronous memory, one write and one registered read port.
`default_nettype none
module rmq_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ design/range_minimum_query.sv @@
// Range minimum query: top level with load path, scan sequencer and output register.
// Usage:
//   in_*  : item stream. tuser = kind (0 load, 1 query). tdata packs load_index,
//           load_value, query_left, query_right from the lowest bit up.
//   out_* : one result per query: tdata = min_position, tuser = range_invalid.
//   cfg_* : user writes array_length only while the block is idle; not enforced.
// A load writes the store directly when it is accepted; it gives no result.
// A valid query scans the store one entry per cycle through the single read
// port, through ST_SCAN and ST_DONE into the output register, so the query
// rate is set by the range length. An invalid query skips the scan.
// The output register holds a result until out_tready; a new item is accepted
// only once the previous result has been taken.
// Reset (rst_n low, synchronous) sets array_length to 1 and clears control
// state; the store contents are undefined until loaded.
// When the receiver stalls, the result holds and input is not accepted.
`default_nettype none
module range_minimum_query #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] load_index, [27:12] load_value, [39:28] query_left, [51:40] query_right
  input  wire logic [55:0] in_tdata,
  // [0] kind
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [11:0] min_position
  output logic [15:0]      out_tdata,
  // [0] range_invalid
  output logic             out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);
  import rmq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = AW + 1;

  logic [POS_BITS-1:0] ld_idx, q_left, q_right;
  logic [IN_VALUE_BITS-1:0] ld_val;
  assign ld_idx  = in_tdata[11:0];
  assign ld_val  = in_tdata[27:12];
  assign q_left  = in_tdata[39:28];
  assign q_right = in_tdata[51:40];

  scan_state_t state_r, state_nxt;
  logic [LEN_BITS-1:0] len_r;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt, cur_r, cur_nxt, end_r, end_nxt;
  logic [CW-1:0] best_pos_r, best_pos_nxt;
  logic signed [VALUE_BITS-1:0] best_val_r, best_val_nxt, rd_data;
  logic first_r, first_nxt;
  logic ov_r, ov_nxt, oinv_r, oinv_nxt;
  logic [POS_BITS-1:0] opos_r, opos_nxt;

  logic accept, is_load, wr_en;
  logic [CW-1:0] eff_len, left_w, right_w;
  logic q_bad;
  logic [AW-1:0] rd_addr;

  assign in_tready = (state_r == ST_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign accept = in_tvalid && in_tready;
  assign is_load = (in_tuser == KIND_LOAD);
  assign wr_en = accept && is_load && (32'(ld_idx) < MAX_ELEMENTS);

  assign left_w  = CW'(q_left);
  assign right_w = CW'(q_right);
  assign eff_len = (32'(len_r) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : CW'(len_r);
  assign q_bad = (q_left > q_right) || (32'(q_right) >= 32'(eff_len));

  assign rd_addr = (state_r == ST_IDLE) ? AW'(q_left) : rd_ptr_r[AW-1:0];

  rmq_store #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_BITS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(ld_idx)),
    .wr_data (VALUE_BITS'(ld_val)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    rd_ptr_nxt   = rd_ptr_r;
    cur_nxt      = cur_r;
    end_nxt      = end_r;
    best_pos_nxt = best_pos_r;
    best_val_nxt = best_val_r;
    first_nxt    = first_r;
    ov_nxt       = ov_r;
    oinv_nxt     = oinv_r;
    opos_nxt     = opos_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_load) begin
          if (q_bad) begin
            ov_nxt   = 1'b1;
            oinv_nxt = 1'b1;
            opos_nxt = '0;
          end else begin
            rd_ptr_nxt = left_w + CW'(1);
            cur_nxt    = left_w;
            end_nxt    = right_w;
            first_nxt  = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        first_nxt = 1'b0;
        if (first_r || (rd_data < best_val_r)) begin
          best_val_nxt = rd_data;
          best_pos_nxt = cur_r;
        end
        cur_nxt = cur_r + CW'(1);
        rd_ptr_nxt = rd_ptr_r + CW'(1);
        if (cur_r == end_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ov_nxt    = 1'b1;
        oinv_nxt  = 1'b0;
        opos_nxt  = POS_BITS'(best_pos_r);
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      len_r   <= LEN_BITS'(1);
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      first_r <= first_nxt;
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    cur_r      <= cur_nxt;
    end_r      <= end_nxt;
    best_pos_r <= best_pos_nxt;
    best_val_r <= best_val_nxt;
    oinv_r     <= oinv_nxt;
    opos_r     <= opos_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, opos_r};
  assign out_tuser  = oinv_r;
endmodule
`default_nettype wire
